### rtl/pced_pkg.sv
package pced_pkg;

  localparam int MAX_BODIES = 32;
  localparam int AW         = $clog2(MAX_BODIES);
  localparam int CW         = $clog2(MAX_BODIES + 1);
  localparam int MASK_W     = 32;
  localparam int IDX_W      = 5;

  // partner test: 10000 * d2 < 14641 * big^2  (1.4641 = 1.21^2)
  localparam int K_W        = 14;
  localparam logic [K_W-1:0] K_DIST = K_W'(10000);
  localparam logic [K_W-1:0] K_RAD  = K_W'(14641);

  localparam int DIFF_W     = 33;
  localparam int SQ_W       = 2 * DIFF_W;
  localparam int D2_W       = SQ_W + 2;
  localparam int CMP_W      = D2_W + K_W;

  typedef struct packed {
    logic               start_of_set;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic        [31:0] crit_radius;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]  body_index;
    logic              central_flag;
    logic [MASK_W-1:0] partner_mask;
    logic              any_encounter;
    logic              overflow;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_ISSUE,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;     // latch the accepted item
    logic store;    // write item into body memory
    logic issue;    // read one stored body into the pipe
    logic finish;   // publish result, update set state
  } cmd_t;

  typedef struct packed {
    logic full;       // set already holds MAX_BODIES
    logic first;      // item is the central body
    logic last_issue; // read address is the last stored body
    logic pipe_busy;
    logic out_free;
  } status_t;

endpackage

### rtl/pced_ctrl.sv
module pced_ctrl import pced_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (status.full || status.first) state_next = ST_FINISH;
        else                             state_next = ST_ISSUE;
      end
      ST_ISSUE: begin
        if (status.last_issue) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!status.pipe_busy) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_DECIDE: cmd.store  = !status.full;
      ST_ISSUE:  cmd.issue  = 1'b1;
      ST_DRAIN:  cmd        = '0;
      ST_FINISH: cmd.finish = status.out_free;
      default:   cmd        = '0;
    endcase
  end

endmodule

### rtl/pced_dp.sv
module pced_dp import pced_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  in_item_t  in_item,
  input  logic      cfg_we,
  input  logic [31:0] cfg_wdata,
  input  cmd_t      cmd,
  output status_t   status,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  logic [127:0] mem [MAX_BODIES];

  logic [31:0]   peri_radius;
  in_item_t      cur;
  logic [CW-1:0] body_count;
  logic          any_seen;
  logic [AW-1:0] rd_addr;

  logic             acc_central;
  logic             acc_any;
  logic [MASK_W-1:0] acc_mask;

  // pipe: read, diff, square, sum, scale
  logic [127:0]        q1;
  logic                v1, v2, v3, v4, v5;
  logic                c1, c2, c3, c4, c5;
  logic [AW-1:0]       a1, a2, a3, a4, a5;
  logic [DIFF_W-1:0]   dx2, dy2, dz2;
  logic [31:0]         big2;
  logic [SQ_W-1:0]     sx3, sy3, sz3;
  logic [63:0]         bb3, bb4;
  logic [D2_W-1:0]     d2_4;
  logic [CMP_W-1:0]    lhs5, rhs5;

  logic                full, first;

  assign full  = body_count >= CW'(MAX_BODIES);
  assign first = body_count == '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      peri_radius <= '0;
    end else if (cfg_we) begin
      peri_radius <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      mem[body_count[AW-1:0]] <= {cur.pos_x, cur.pos_y, cur.pos_z, cur.crit_radius};
    end
    if (cmd.issue) begin
      q1 <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) cur <= in_item;
  end

  function automatic logic [DIFF_W-1:0] absdiff(logic [31:0] a, logic [31:0] b);
    logic signed [DIFF_W-1:0] d;
    d = $signed({a[31], a}) - $signed({b[31], b});
    return d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
  endfunction

  // datapath registers without reset
  always_ff @(posedge clk) begin
    a1   <= rd_addr;
    c1   <= rd_addr == '0;
    dx2  <= absdiff(q1[127:96], cur.pos_x);
    dy2  <= absdiff(q1[95:64],  cur.pos_y);
    dz2  <= absdiff(q1[63:32],  cur.pos_z);
    big2 <= c1 ? peri_radius :
            (q1[31:0] > cur.crit_radius ? q1[31:0] : cur.crit_radius);
    c2   <= c1;
    a2   <= a1;
    sx3  <= SQ_W'(dx2) * SQ_W'(dx2);
    sy3  <= SQ_W'(dy2) * SQ_W'(dy2);
    sz3  <= SQ_W'(dz2) * SQ_W'(dz2);
    bb3  <= 64'(big2) * 64'(big2);
    c3   <= c2;
    a3   <= a2;
    d2_4 <= D2_W'(sx3) + D2_W'(sy3) + D2_W'(sz3);
    bb4  <= bb3;
    c4   <= c3;
    a4   <= a3;
    lhs5 <= c4 ? CMP_W'(d2_4) : CMP_W'(d2_4) * CMP_W'(K_DIST);
    rhs5 <= c4 ? CMP_W'(bb4)  : CMP_W'(bb4)  * CMP_W'(K_RAD);
    c5   <= c4;
    a5   <= a4;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1; v3 <= v2; v4 <= v3; v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_addr <= '0;
    end else if (cmd.load) begin
      rd_addr <= '0;
    end else if (cmd.issue) begin
      rd_addr <= rd_addr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      acc_central <= 1'b0;
      acc_any     <= 1'b0;
      acc_mask    <= '0;
    end else if (v5 && lhs5 < rhs5) begin
      acc_any <= 1'b1;
      if (c5) acc_central <= 1'b1;
      else    acc_mask    <= acc_mask | (MASK_W'(1) << a5);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      body_count <= '0;
      any_seen   <= 1'b0;
    end else if (cmd.load && (in_item.start_of_set || body_count == '0)) begin
      body_count <= '0;
      any_seen   <= 1'b0;
    end else if (cmd.finish && !full) begin
      body_count <= body_count + CW'(1);
      any_seen   <= any_seen | acc_any;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (full) begin
        out_item <= '{body_index: '0, central_flag: 1'b0, partner_mask: '0,
                      any_encounter: any_seen, overflow: 1'b1};
      end else begin
        out_item <= '{body_index: IDX_W'(body_count), central_flag: acc_central,
                      partner_mask: acc_mask, any_encounter: any_seen | acc_any,
                      overflow: 1'b0};
      end
    end
  end

  always_comb begin
    status.full       = full;
    status.first      = first;
    status.last_issue = CW'(rd_addr) == body_count - CW'(1);
    status.pipe_busy  = v1 | v2 | v3 | v4 | v5;
    status.out_free   = !out_valid || out_ready;
  end

endmodule

### rtl/pairwise_close_encounter_detector.sv
// channel | dir | handshake            | payload
// in      | in  | in_valid / in_ready  | in_item (in_item_t)
// out     | out | out_valid / out_ready| out_item (out_item_t)
// cfg     | in  | cfg_we               | cfg_wdata (peri_radius)
//
// Sequence: a body with n stored predecessors goes from accept to result
// through decide, n read issues, 5-stage distance pipe, accumulate, finish;
// first body of a set and overflow go straight from decide to finish. The
// next item can be accepted once the result is registered. Sweeps use the
// single distance pipe and one memory read port, one stored body per cycle.
// Reset: rst synchronous, clears set state, peri_radius, and handshakes.
// Stalls: the next item is accepted while a result waits in the output
// register; finish waits only if that register is still occupied.
module pairwise_close_encounter_detector import pced_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_item,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  cmd_t    cmd;      // controller -> datapath
  status_t status;   // datapath -> controller

  // sequencer: accept, store, sweep stored bodies, drain, publish
  pced_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // body memory, distance pipe, accumulators, output register
  pced_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

### rtl/pced_checker.sv
module pced_checker import pced_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_item
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result after reset");

  a_ovf: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.overflow |->
      out_item.partner_mask == '0 && !out_item.central_flag && out_item.body_index == '0)
    else $error("overflow result carries data");

  a_central: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.overflow && out_item.body_index == '0 |->
      out_item.partner_mask == '0 && !out_item.central_flag && !out_item.any_encounter)
    else $error("central body result not clean");

  a_bit0: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !out_item.partner_mask[0])
    else $error("central body in partner mask");

endmodule

bind pairwise_close_encounter_detector pced_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);
